### hdl/iole_pkg.sv
// ----------------------------------------------------------------------------
// iole_pkg
// Shared types and constants for the indexed ordered list engine: command
// and status codes, transaction payloads and controller/datapath handshakes.
// ----------------------------------------------------------------------------
package iole_pkg;

   localparam int CMD_W       = 3;
   localparam int POS_W       = 6;
   localparam int VAL_W       = 32;
   localparam int ST_W        = 2;
   localparam int LEN_W       = 6;
   localparam int MAX_RESULTS = 32;

   localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH    = 3'd0,
      CMD_APPEND  = 3'd1,
      CMD_INSERT  = 3'd2,
      CMD_DELETE  = 3'd3,
      CMD_READ    = 3'd4,
      CMD_REVERSE = 3'd5,
      CMD_CLEAR   = 3'd6,
      CMD_DISPLAY = 3'd7
   } cmd_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic [POS_W-1:0]         position;
      logic signed [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0]  element;
      status_type               status;
      logic [LEN_W-1:0]         length;
      logic                     last;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic apply;      // execute the held command on the cells
      logic load_rsp;   // load the output register
      logic shift;      // one shift-down step of a reverse
      logic show_step;  // emit the next element of a display
   } iole_ctl_type;

   // Datapath to controller status
   typedef struct packed {
      logic disp_go;     // display of a non-empty list
      logic needs_shift; // reverse leaves a shift-down pass to do
      logic shift_last;  // final shift-down step
      logic show_last;   // final element of a display
   } iole_sts_type;

endpackage

### hdl/indexed_ordered_list_engine_core.sv
// A single-result command is accepted in the idle state and executed in the
// exec state, which loads the output register; one transaction is taken at a
// time, and a waiting result that is not taken holds execution.
// Reverse of two or more elements, fewer than CAPACITY, adds a shift-down pass;
// display of a non-empty list streams one result per element shown.
// Reset clears the length and the controller; cell contents stay undefined.
// ----------------------------------------------------------------------------
// indexed_ordered_list_engine_core
// Bounded ordered list of signed 32-bit values held in shifting cells, with
// push, append, insert, delete, read, reverse, clear and display commands.
// ----------------------------------------------------------------------------
module indexed_ordered_list_engine_core
   import iole_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   iole_ctl_type ctl;
   iole_sts_type sts;
   logic         req_accept;

   assign req_accept = req_valid && req_ready;

   // Sequencer
   iole_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // List cells and result formation
   iole_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_data   (rsp_data)
   );

endmodule

### hdl/iole_datapath.sv
// ----------------------------------------------------------------------------
// iole_datapath
// Shifting list cells, element count, command evaluation and the output
// register. Insert and delete shift the cells on apply; reverse mirrors
// the whole row and then shifts the elements down into place.
// ----------------------------------------------------------------------------
module iole_datapath
   import iole_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_accept,
   input  req_type      req_data,
   input  iole_ctl_type ctl,
   output iole_sts_type sts,
   output rsp_type      rsp_data
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int IW   = $clog2(CAPACITY);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   req_type                 req_ff;
   logic signed [VAL_W-1:0] cells_ff [CAPACITY];
   logic signed [VAL_W-1:0] cells_in [CAPACITY];
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           shcnt_ff, shcnt_in;
   logic [IW-1:0]           idx_ff, idx_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [CMPW-1:0]         posx, cntx, capx, maxx, ipx, nx;
   logic                    is_ins, ins_range, ins_full, ins_ok;
   logic                    is_del, empty, pos_miss, del_ok;
   logic                    rev_mirror;
   logic [IW-1:0]           rd_idx;
   logic signed [VAL_W-1:0] rd_data;
   status_type              res_status;
   logic signed [VAL_W-1:0] res_element;

   // Hold the transaction under execution
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
      end
   end

   // Decode the held command against the current length
   always_comb begin
      posx      = CMPW'(req_ff.position);
      cntx      = CMPW'(count_ff);
      capx      = CMPW'(CAPACITY);
      maxx      = CMPW'(MAX_RESULTS);
      is_ins    = (req_ff.cmd == CMD_PUSH) || (req_ff.cmd == CMD_APPEND) ||
                  (req_ff.cmd == CMD_INSERT);
      case (req_ff.cmd)
         CMD_PUSH:   ipx = '0;
         CMD_APPEND: ipx = cntx;
         default:    ipx = posx;
      endcase
      ins_range  = ipx > cntx;
      ins_full   = cntx >= capx;
      ins_ok     = is_ins && !ins_range && !ins_full;
      is_del     = req_ff.cmd == CMD_DELETE;
      empty      = count_ff == '0;
      pos_miss   = posx >= cntx;
      del_ok     = is_del && !empty && !pos_miss;
      rev_mirror = (req_ff.cmd == CMD_REVERSE) && (cntx > CMPW'(1));
      nx         = (cntx > maxx) ? maxx : cntx;
   end

   // Report to the controller
   always_comb begin
      sts.disp_go     = (req_ff.cmd == CMD_DISPLAY) && !empty;
      sts.needs_shift = rev_mirror && (cntx != capx);
      sts.shift_last  = shcnt_ff == CW'(1);
      sts.show_last   = (CMPW'(idx_ff) + CMPW'(1)) == nx;
   end

   // Single read port: display index or requested position
   always_comb begin
      rd_idx  = ctl.show_step ? idx_ff : IW'(req_ff.position);
      rd_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (IW'(i) == rd_idx) begin
            rd_data = cells_ff[i];
         end
      end
   end

   // Shift, place or mirror the cells
   always_comb begin
      logic [CMPW-1:0] ix;
      ix = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         ix          = CMPW'(i);
         cells_in[i] = cells_ff[i];
         if (ctl.apply && ins_ok) begin
            if (ix == ipx) begin
               cells_in[i] = req_ff.value;
            end else if (ix > ipx) begin
               cells_in[i] = cells_ff[(i + CAPACITY - 1) % CAPACITY];
            end
         end else if (ctl.apply && del_ok) begin
            if ((ix >= posx) && (i < CAPACITY - 1)) begin
               cells_in[i] = cells_ff[(i + 1) % CAPACITY];
            end
         end else if (ctl.shift) begin
            if (i < CAPACITY - 1) begin
               cells_in[i] = cells_ff[(i + 1) % CAPACITY];
            end
         end else if (ctl.apply && rev_mirror) begin
            cells_in[i] = cells_ff[CAPACITY - 1 - i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_ff[i] <= cells_in[i];
      end
   end

   // Advance the count, shift counter and display index
   always_comb begin
      count_in = count_ff;
      shcnt_in = shcnt_ff;
      idx_in   = idx_ff;
      if (ctl.apply) begin
         shcnt_in = CW'(capx - cntx);
         if (ins_ok) begin
            count_in = count_ff + CW'(1);
         end else if (del_ok) begin
            count_in = count_ff - CW'(1);
         end else if (req_ff.cmd == CMD_CLEAR) begin
            count_in = '0;
         end
      end
      if (ctl.shift) begin
         shcnt_in = shcnt_ff - CW'(1);
      end
      if (req_accept) begin
         idx_in = '0;
      end else if (ctl.show_step) begin
         idx_in = idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      shcnt_ff <= shcnt_in;
      idx_ff   <= idx_in;
   end

   // Form the result of a single-result command
   always_comb begin
      res_element = '0;
      res_status  = ST_OK;
      case (req_ff.cmd)
         CMD_PUSH, CMD_APPEND, CMD_INSERT: begin
            if (ins_range) begin
               res_status = ST_RANGE;
            end else if (ins_full) begin
               res_status = ST_FULL;
            end
         end
         CMD_DELETE: begin
            if (empty) begin
               res_status = ST_EMPTY;
            end else if (pos_miss) begin
               res_status = ST_RANGE;
            end
         end
         CMD_READ: begin
            if (empty) begin
               res_status  = ST_EMPTY;
               res_element = MISS_VALUE;
            end else if (pos_miss) begin
               res_status  = ST_RANGE;
               res_element = MISS_VALUE;
            end else begin
               res_element = rd_data;
            end
         end
         CMD_DISPLAY: res_status = ST_EMPTY;
         default:     res_status = ST_OK;
      endcase
   end

   // Load the output register
   always_comb begin
      rsp_in = rsp_ff;
      if (ctl.load_rsp) begin
         if (ctl.show_step) begin
            rsp_in.element = rd_data;
            rsp_in.status  = ST_OK;
            rsp_in.length  = LEN_W'(count_ff);
            rsp_in.last    = sts.show_last;
         end else begin
            rsp_in.element = res_element;
            rsp_in.status  = res_status;
            rsp_in.length  = LEN_W'(count_in);
            rsp_in.last    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   // Checks
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      CMPW'(count_ff) <= capx)
      else $error("element count exceeds capacity");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      (ctl.apply && ins_ok) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("accepted insert did not grow the list");

   a_shift_keeps_count : assert property (@(posedge clock) disable iff (reset)
      ctl.shift |=> $stable(count_ff))
      else $error("reverse shift changed the element count");

endmodule

### hdl/iole_controller.sv
// ----------------------------------------------------------------------------
// iole_controller
// Sequencer for the list engine: takes one transaction at a time, runs the
// reverse shift pass and the display stream, and owns the output valid.
// ----------------------------------------------------------------------------
module iole_controller
   import iole_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  iole_sts_type sts,
   output iole_ctl_type ctl
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXEC  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_SHOW  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // Output register may be refilled when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.disp_go) begin
               state_in = ST_SHOW;
            end else if (slot_free) begin
               ctl.apply    = 1'b1;
               ctl.load_rsp = 1'b1;
               state_in     = sts.needs_shift ? ST_SHIFT : ST_IDLE;
            end
         end
         ST_SHIFT: begin
            ctl.shift = 1'b1;
            if (sts.shift_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_SHOW: begin
            if (slot_free) begin
               ctl.show_step = 1'b1;
               ctl.load_rsp  = 1'b1;
               if (sts.show_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the output valid until the result is taken
   always_comb begin
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Checks
   a_accept_to_exec : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted transaction did not enter execution");

endmodule
